// ===== hdl/islt_pkg.sv =====
// Shared types and constants for the innermost span lookup table.
`timescale 1ns / 1ps

package islt_pkg;

	localparam int DEF_MAX_ENTRIES = 256;
	localparam int DEF_COORD_BITS  = 16;
	localparam int FIELD_W         = 16;
	localparam int REQ_W           = 2;
	localparam int STAT_W          = 2;
	localparam int INDEX_W         = 8;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD    = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} stat_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic do_add;
		logic do_clear;
		logic ack_ok;
		logic start_lookup;
		logic scan_issue;
		logic finish_lookup;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic scan_last;
	} dp_sts_t;

endpackage

// ===== hdl/islt_if.sv =====
// Request and response channel interfaces.
`timescale 1ns / 1ps

interface islt_req_if;
	logic                        valid;
	logic                        ready;
	logic [islt_pkg::REQ_W-1:0]  req_type;
	logic [islt_pkg::FIELD_W-1:0] line_no;
	logic [islt_pkg::FIELD_W-1:0] column;
	logic [islt_pkg::FIELD_W-1:0] end_column;

	modport source (output valid, req_type, line_no, column, end_column, input ready);
	modport sink (input valid, req_type, line_no, column, end_column, output ready);
endinterface

interface islt_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [islt_pkg::STAT_W-1:0]  status;
	logic [islt_pkg::INDEX_W-1:0] entry_index;

	modport source (output valid, status, entry_index, input ready);
	modport sink (input valid, status, entry_index, output ready);
endinterface

// ===== hdl/islt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module islt_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/islt_dp.sv =====
// Datapath: span store, entry count, lookup scan and response register.
`timescale 1ns / 1ps

module islt_dp #(
	parameter int MAX_ENTRIES = islt_pkg::DEF_MAX_ENTRIES,
	parameter int COORD_BITS  = islt_pkg::DEF_COORD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  islt_pkg::ctrl_cmd_t           cmd,
	input  logic [islt_pkg::FIELD_W-1:0]  line_no,
	input  logic [islt_pkg::FIELD_W-1:0]  column,
	input  logic [islt_pkg::FIELD_W-1:0]  end_column,
	output islt_pkg::dp_sts_t             sts,
	output logic [islt_pkg::STAT_W-1:0]   status,
	output logic [islt_pkg::INDEX_W-1:0]  entry_index
);

	import islt_pkg::*;

	localparam int IDX_W  = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int SPAN_W = 3 * COORD_BITS;

	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      scan_addr_q;
	logic                  pend_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [COORD_BITS-1:0] key_line_q;
	logic [COORD_BITS-1:0] key_col_q;
	logic                  found_q;
	logic [IDX_W-1:0]      best_q;
	logic [COORD_BITS-1:0] best_w_q;
	stat_t                 stat_q;
	logic [INDEX_W-1:0]    index_q;

	logic [COORD_BITS-1:0] in_line;
	logic [COORD_BITS-1:0] in_col;
	logic [COORD_BITS-1:0] in_end;
	logic                  full;
	logic                  wr_en;
	logic [SPAN_W-1:0]     rd_span;
	logic [COORD_BITS-1:0] rd_line;
	logic [COORD_BITS-1:0] rd_start;
	logic [COORD_BITS-1:0] rd_stop;
	logic [COORD_BITS-1:0] rd_width;
	logic                  covers;
	logic                  better;

	assign in_line = COORD_BITS'(line_no);
	assign in_col  = COORD_BITS'(column);
	assign in_end  = COORD_BITS'(end_column);

	assign full  = (count_q == CNT_W'(MAX_ENTRIES));
	assign wr_en = cmd.do_add && !full;

	islt_ram #(
		.WIDTH(SPAN_W),
		.DEPTH(MAX_ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[IDX_W-1:0]),
		.wdata ({in_line, in_col, in_end}),
		.raddr (scan_addr_q),
		.rdata (rd_span)
	);

	assign rd_line  = rd_span[SPAN_W-1 -: COORD_BITS];
	assign rd_start = rd_span[2*COORD_BITS-1 -: COORD_BITS];
	assign rd_stop  = rd_span[COORD_BITS-1:0];
	assign rd_width = rd_stop - rd_start;
	assign covers   = (rd_line == key_line_q) && (key_col_q >= rd_start) &&
	                  (key_col_q < rd_stop);
	// Strict compare keeps the earliest entry on equal widths.
	assign better   = pend_s1 && covers && (!found_q || (rd_width < best_w_q));

	assign sts.empty     = (count_q == '0);
	assign sts.scan_last = ((CNT_W'(scan_addr_q) + CNT_W'(1)) == count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			scan_addr_q <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (cmd.do_clear) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.start_lookup) begin
				scan_addr_q <= '0;
				found_q     <= 1'b0;
			end else begin
				if (cmd.scan_issue) begin
					scan_addr_q <= scan_addr_q + IDX_W'(1);
				end
				if (better) begin
					found_q <= 1'b1;
				end
			end
			pend_s1 <= cmd.scan_issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_addr_q;
		if (cmd.start_lookup) begin
			key_line_q <= in_line;
			key_col_q  <= in_col;
		end
		if (better) begin
			best_q   <= idx_s1;
			best_w_q <= rd_width;
		end
		if (cmd.do_add) begin
			stat_q  <= full ? STAT_FULL : STAT_OK;
			index_q <= full ? '0 : INDEX_W'(count_q);
		end else if (cmd.do_clear || cmd.ack_ok) begin
			stat_q  <= STAT_OK;
			index_q <= '0;
		end else if (cmd.finish_lookup) begin
			stat_q  <= found_q ? STAT_OK : STAT_NOT_FOUND;
			index_q <= found_q ? INDEX_W'(best_q) : '0;
		end
	end

	assign status      = stat_q;
	assign entry_index = index_q;

endmodule

// ===== hdl/islt_ctrl.sv =====
// Controller: request decode, lookup scan sequencing and response valid.
`timescale 1ns / 1ps

module islt_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic [islt_pkg::REQ_W-1:0]  req_type,
	input  logic                        rsp_ready,
	input  islt_pkg::dp_sts_t           sts,
	output islt_pkg::ctrl_cmd_t         cmd,
	output logic                        req_ready,
	output logic                        rsp_valid
);

	import islt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   accept;
	logic   rsp_set;
	req_t   req;

	assign req       = req_t'(req_type);
	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	// Raise the result beat at accept for non-lookup requests and at the end of a lookup.
	assign rsp_set   = (accept && (req != REQ_LOOKUP)) || (state_q == S_FINISH);

	always_comb begin
		cmd               = '0;
		cmd.scan_issue    = (state_q == S_SCAN);
		cmd.finish_lookup = (state_q == S_FINISH);
		if (accept) begin
			unique case (req)
				REQ_ADD:    cmd.do_add       = 1'b1;
				REQ_LOOKUP: cmd.start_lookup = 1'b1;
				REQ_CLEAR:  cmd.do_clear     = 1'b1;
				default:    cmd.ack_ok       = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_set) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && (req == REQ_LOOKUP)) begin
						// Empty table: nothing to scan.
						state_q <= sts.empty ? S_FINISH : S_SCAN;
					end
				end
				S_SCAN: begin
					if (sts.scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// Last read compares here.
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/innermost_span_lookup_table_unit.sv =====
// Innermost span lookup table: top level joining controller and datapath.
// Add, clear and unused requests: result registered at the accept edge.
// Lookup: S_SCAN does one span store read a cycle, S_DRAIN compares the last read and
//   S_FINISH registers the result; an empty table goes straight to S_FINISH.
// One request is in work at a time; a new request is taken once the last result is taken,
//   at the same edge at the earliest.
// Reset is asynchronous, active low: the table is emptied, no result is pending.
`timescale 1ns / 1ps

module innermost_span_lookup_table_unit #(
	parameter int MAX_ENTRIES = islt_pkg::DEF_MAX_ENTRIES,
	parameter int COORD_BITS  = islt_pkg::DEF_COORD_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	islt_req_if.sink      req,
	islt_rsp_if.source    rsp
);

	import islt_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	islt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid)
	);

	islt_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.COORD_BITS  (COORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.line_no     (req.line_no),
		.column      (req.column),
		.end_column  (req.end_column),
		.sts         (sts),
		.status      (rsp.status),
		.entry_index (rsp.entry_index)
	);

endmodule
